// ----- sv/ttf_pkg.sv -----
package ttf_pkg;

    localparam int POS_W   = 32;
    localparam int TEX_W   = 24;
    localparam int UNIT_W  = 16;
    localparam int FRAC_W  = 14;

    localparam int E_W     = POS_W + 1;
    localparam int D_W     = TEX_W + 1;
    localparam int M_W     = 31;
    localparam int OP_W    = (E_W > M_W + 2) ? E_W : M_W + 2;
    localparam int PROD_W  = 2 * OP_W;
    localparam int VEC_W   = E_W + D_W + 2;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int SREM_W  = ROOT_W + 4;
    localparam int QB      = FRAC_W + 2;
    localparam int NUM_W   = M_W + FRAC_W + 1;
    localparam int DREM_W  = ROOT_W + 1;
    localparam int CNT_W   = $clog2(ROOT_W);

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [TEX_W-1:0] u;
        logic signed [TEX_W-1:0] v;
    } corner_t;

    typedef struct packed {
        logic signed [E_W-1:0] e1x;
        logic signed [E_W-1:0] e1y;
        logic signed [E_W-1:0] e1z;
        logic signed [E_W-1:0] e2x;
        logic signed [E_W-1:0] e2y;
        logic signed [E_W-1:0] e2z;
        logic signed [D_W-1:0] du1;
        logic signed [D_W-1:0] dv1;
        logic signed [D_W-1:0] du2;
        logic signed [D_W-1:0] dv2;
    } tri_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] tx;
        logic signed [UNIT_W-1:0] ty;
        logic signed [UNIT_W-1:0] tz;
        logic signed [UNIT_W-1:0] bx;
        logic signed [UNIT_W-1:0] by;
        logic signed [UNIT_W-1:0] bz;
        logic signed [UNIT_W-1:0] nx;
        logic signed [UNIT_W-1:0] ny;
        logic signed [UNIT_W-1:0] nz;
        logic                     deg;
    } res_t;

endpackage

// ----- sv/ttf_front.sv -----
module ttf_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [ttf_pkg::POS_W-1:0] pos_x,
    input  logic signed [ttf_pkg::POS_W-1:0] pos_y,
    input  logic signed [ttf_pkg::POS_W-1:0] pos_z,
    input  logic signed [ttf_pkg::TEX_W-1:0] tex_u,
    input  logic signed [ttf_pkg::TEX_W-1:0] tex_v,
    output logic                             q_push,
    output ttf_pkg::tri_t                    q_data,
    input  logic                             q_full
);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    ttf_pkg::corner_t c0_reg;
    ttf_pkg::corner_t c1_reg;
    logic             accept;
    logic             third;

    assign third  = (cnt_reg == 2'd2);
    assign full   = third & q_full;
    assign accept = push & ~full;
    assign q_push = accept & third;

    // edge and uv deltas relative to the first corner
    always_comb
    begin
        q_data.e1x = ttf_pkg::E_W'(c1_reg.x) - ttf_pkg::E_W'(c0_reg.x);
        q_data.e1y = ttf_pkg::E_W'(c1_reg.y) - ttf_pkg::E_W'(c0_reg.y);
        q_data.e1z = ttf_pkg::E_W'(c1_reg.z) - ttf_pkg::E_W'(c0_reg.z);
        q_data.e2x = ttf_pkg::E_W'(pos_x) - ttf_pkg::E_W'(c0_reg.x);
        q_data.e2y = ttf_pkg::E_W'(pos_y) - ttf_pkg::E_W'(c0_reg.y);
        q_data.e2z = ttf_pkg::E_W'(pos_z) - ttf_pkg::E_W'(c0_reg.z);
        q_data.du1 = ttf_pkg::D_W'(c1_reg.u) - ttf_pkg::D_W'(c0_reg.u);
        q_data.dv1 = ttf_pkg::D_W'(c1_reg.v) - ttf_pkg::D_W'(c0_reg.v);
        q_data.du2 = ttf_pkg::D_W'(tex_u) - ttf_pkg::D_W'(c0_reg.u);
        q_data.dv2 = ttf_pkg::D_W'(tex_v) - ttf_pkg::D_W'(c0_reg.v);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = third ? 2'd0 : cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cnt_reg == 2'd0)
        begin
            c0_reg <= '{x: pos_x, y: pos_y, z: pos_z, u: tex_u, v: tex_v};
        end
        if (accept && cnt_reg == 2'd1)
        begin
            c1_reg <= '{x: pos_x, y: pos_y, z: pos_z, u: tex_u, v: tex_v};
        end
    end

endmodule

// ----- sv/ttf_queue.sv -----
module ttf_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ttf_pkg::tri_t din,
    output logic          full,
    input  logic          pop,
    output ttf_pkg::tri_t dout,
    output logic          empty
);

    ttf_pkg::tri_t mem_reg [2];
    logic          wr_reg;
    logic          rd_reg;
    logic [1:0]    cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign dout    = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

// ----- sv/ttf_engine.sv -----
module ttf_engine
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ttf_pkg::tri_t q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          pop,
    output ttf_pkg::res_t res
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL0  = 4'd1;
    localparam logic [3:0] ST_MUL1  = 4'd2;
    localparam logic [3:0] ST_COMB  = 4'd3;
    localparam logic [3:0] ST_UCHK  = 4'd4;
    localparam logic [3:0] ST_USHF  = 4'd5;
    localparam logic [3:0] ST_SQM   = 4'd6;
    localparam logic [3:0] ST_SQA   = 4'd7;
    localparam logic [3:0] ST_SQRT  = 4'd8;
    localparam logic [3:0] ST_DINIT = 4'd9;
    localparam logic [3:0] ST_DIV   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    localparam logic [1:0] PH_DET = 2'd0;
    localparam logic [1:0] PH_TAN = 2'd1;
    localparam logic [1:0] PH_BIT = 2'd2;
    localparam logic [1:0] PH_NRM = 2'd3;

    localparam int VW = ttf_pkg::VEC_W;
    localparam int MW = ttf_pkg::M_W;
    localparam int UW = ttf_pkg::UNIT_W;

    logic [3:0]                        state_reg, state_next;
    logic [1:0]                        phase_reg, phase_next;
    logic [1:0]                        comp_reg, comp_next;
    logic [ttf_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                              ov_reg, ov_next;

    ttf_pkg::tri_t                     tri_reg;
    logic signed [ttf_pkg::PROD_W-1:0] p0_reg, p1_reg;
    logic signed [VW-1:0]              vec_reg [3];
    logic [VW-1:0]                     mag_reg [3];
    logic [2:0]                        ng_reg;
    logic                              det_neg_reg;
    logic                              deg_reg;
    logic [ttf_pkg::SQ_W-1:0]          s2_reg;
    logic [ttf_pkg::SQ_W-1:0]          sqn_reg;
    logic [ttf_pkg::SREM_W-1:0]        srem_reg;
    logic [ttf_pkg::ROOT_W-1:0]        root_reg;
    logic [ttf_pkg::DREM_W-1:0]        drem_reg;
    logic [ttf_pkg::QB-1:0]            dsh_reg;
    logic [ttf_pkg::QB-1:0]            q_reg;
    logic signed [UW-1:0]              tq_reg [3];
    logic signed [UW-1:0]              bq_reg [3];
    logic signed [UW-1:0]              nq_reg [3];
    ttf_pkg::res_t                     res_reg;

    logic signed [ttf_pkg::OP_W-1:0]   opa, opb;
    logic signed [ttf_pkg::PROD_W-1:0] prod;
    logic signed [VW-1:0]              diff;
    logic signed [ttf_pkg::E_W-1:0]    e1c, e2c;
    logic [VW-1:0]                     absv [3];
    logic [VW-1:0]                     or_m;
    logic                              m_hi, m_top, all_zero;
    logic [MW-1:0]                     msel;
    logic [ttf_pkg::SQ_W-1:0]          s2_sum;
    logic [ttf_pkg::SREM_W-1:0]        sr2, strial;
    logic                              sge;
    logic [ttf_pkg::NUM_W-1:0]         num;
    logic [ttf_pkg::DREM_W-1:0]        dr2;
    logic                              dge;
    logic [ttf_pkg::QB-1:0]            q_new;
    logic                              flip;
    logic signed [UW-1:0]              qval;
    logic                              load_out;
    logic                              cnt_last_sqrt, cnt_last_div;

    assign q_pop     = (state_reg == ST_IDLE) & ~q_empty;
    assign out_valid = ov_reg;
    assign res       = res_reg;
    assign load_out  = (state_reg == ST_DONE) & (~ov_reg | pop);

    assign cnt_last_sqrt = (cnt_reg == ttf_pkg::CNT_W'(ttf_pkg::ROOT_W - 1));
    assign cnt_last_div  = (cnt_reg == ttf_pkg::CNT_W'(ttf_pkg::QB - 1));

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    begin e1c = tri_reg.e1x; e2c = tri_reg.e2x; end
            2'd1:    begin e1c = tri_reg.e1y; e2c = tri_reg.e2y; end
            default: begin e1c = tri_reg.e1z; e2c = tri_reg.e2z; end
        endcase
    end

    assign msel = mag_reg[comp_reg][MW-1:0];

    // shared multiplier operand select
    always_comb
    begin
        opa = '0;
        opb = '0;
        if (state_reg == ST_SQM)
        begin
            opa = $signed({{(ttf_pkg::OP_W - MW){1'b0}}, msel});
            opb = opa;
        end
        else if (state_reg == ST_MUL0 || state_reg == ST_MUL1)
        begin
            unique case (phase_reg)
                PH_DET:
                begin
                    if (state_reg == ST_MUL0)
                    begin
                        opa = ttf_pkg::OP_W'(tri_reg.du1);
                        opb = ttf_pkg::OP_W'(tri_reg.dv2);
                    end
                    else
                    begin
                        opa = ttf_pkg::OP_W'(tri_reg.du2);
                        opb = ttf_pkg::OP_W'(tri_reg.dv1);
                    end
                end
                PH_TAN:
                begin
                    if (state_reg == ST_MUL0)
                    begin
                        opa = ttf_pkg::OP_W'(tri_reg.dv2);
                        opb = ttf_pkg::OP_W'(e1c);
                    end
                    else
                    begin
                        opa = ttf_pkg::OP_W'(tri_reg.dv1);
                        opb = ttf_pkg::OP_W'(e2c);
                    end
                end
                PH_BIT:
                begin
                    if (state_reg == ST_MUL0)
                    begin
                        opa = ttf_pkg::OP_W'(tri_reg.du1);
                        opb = ttf_pkg::OP_W'(e2c);
                    end
                    else
                    begin
                        opa = ttf_pkg::OP_W'(tri_reg.du2);
                        opb = ttf_pkg::OP_W'(e1c);
                    end
                end
                default:
                begin
                    unique case (comp_reg)
                        2'd0:
                        begin
                            opa = ttf_pkg::OP_W'((state_reg == ST_MUL0) ? tq_reg[1] : tq_reg[2]);
                            opb = ttf_pkg::OP_W'((state_reg == ST_MUL0) ? bq_reg[2] : bq_reg[1]);
                        end
                        2'd1:
                        begin
                            opa = ttf_pkg::OP_W'((state_reg == ST_MUL0) ? tq_reg[2] : tq_reg[0]);
                            opb = ttf_pkg::OP_W'((state_reg == ST_MUL0) ? bq_reg[0] : bq_reg[2]);
                        end
                        default:
                        begin
                            opa = ttf_pkg::OP_W'((state_reg == ST_MUL0) ? tq_reg[0] : tq_reg[1]);
                            opb = ttf_pkg::OP_W'((state_reg == ST_MUL0) ? bq_reg[1] : bq_reg[0]);
                        end
                    endcase
                end
            endcase
        end
    end

    assign prod = opa * opb;
    assign diff = VW'(p0_reg - p1_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            absv[i] = vec_reg[i][VW-1] ? VW'(-vec_reg[i]) : VW'(vec_reg[i]);
        end
    end

    assign all_zero = (absv[0] == '0) & (absv[1] == '0) & (absv[2] == '0);
    assign or_m     = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign m_hi     = |or_m[VW-1:MW];
    assign m_top    = or_m[MW-1];
    assign s2_sum   = s2_reg + p0_reg[ttf_pkg::SQ_W-1:0];

    // bit-pair square root step
    assign sr2    = {srem_reg[ttf_pkg::SREM_W-3:0], sqn_reg[ttf_pkg::SQ_W-1 -: 2]};
    assign strial = {2'b00, root_reg, 2'b01};
    assign sge    = (sr2 >= strial);

    // rounded quotient numerator and restoring divide step
    assign num   = ttf_pkg::NUM_W'({msel, {ttf_pkg::FRAC_W{1'b0}}})
                 + ttf_pkg::NUM_W'(root_reg >> 1);
    assign dr2   = {drem_reg[ttf_pkg::DREM_W-2:0], dsh_reg[ttf_pkg::QB-1]};
    assign dge   = (dr2 >= {1'b0, root_reg});
    assign q_new = {q_reg[ttf_pkg::QB-2:0], dge};
    assign flip  = ng_reg[comp_reg] ^ ((phase_reg != PH_NRM) & det_neg_reg);
    assign qval  = flip ? -UW'(q_new) : UW'(q_new);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        if (pop && ov_reg)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_MUL0;
                    phase_next = PH_DET;
                    comp_next  = 2'd0;
                end
            end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_COMB;
            ST_COMB:
            begin
                if (phase_reg == PH_DET)
                begin
                    if (diff == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL0;
                        phase_next = PH_TAN;
                        comp_next  = 2'd0;
                    end
                end
                else if (comp_reg == 2'd2)
                begin
                    state_next = ST_UCHK;
                    comp_next  = 2'd0;
                end
                else
                begin
                    state_next = ST_MUL0;
                    comp_next  = comp_reg + 2'd1;
                end
            end
            ST_UCHK: state_next = all_zero ? ST_DONE : ST_USHF;
            ST_USHF:
            begin
                if (!m_hi && m_top)
                begin
                    state_next = ST_SQM;
                    comp_next  = 2'd0;
                end
            end
            ST_SQM: state_next = ST_SQA;
            ST_SQA:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = ST_SQM;
                    comp_next  = comp_reg + 2'd1;
                end
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + ttf_pkg::CNT_W'(1);
                if (cnt_last_sqrt)
                begin
                    state_next = ST_DINIT;
                    comp_next  = 2'd0;
                end
            end
            ST_DINIT:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + ttf_pkg::CNT_W'(1);
                if (cnt_last_div)
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_next = 2'd0;
                        if (phase_reg == PH_NRM)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_MUL0;
                            phase_next = phase_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        state_next = ST_DINIT;
                        comp_next  = comp_reg + 2'd1;
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                    ov_next    = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DET;
            comp_reg  <= 2'd0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                tri_reg <= q_data;
                deg_reg <= 1'b0;
            end
            ST_MUL0: p0_reg <= prod;
            ST_MUL1: p1_reg <= prod;
            ST_COMB:
            begin
                if (phase_reg == PH_DET)
                begin
                    det_neg_reg <= diff[VW-1];
                    deg_reg     <= (diff == '0);
                end
                else
                begin
                    vec_reg[comp_reg] <= diff;
                end
            end
            ST_UCHK:
            begin
                deg_reg <= all_zero;
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= absv[i];
                    ng_reg[i]  <= vec_reg[i][VW-1];
                end
            end
            ST_USHF:
            begin
                s2_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    if (m_hi)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (!m_top)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            ST_SQM: p0_reg <= prod;
            ST_SQA:
            begin
                s2_reg   <= s2_sum;
                sqn_reg  <= s2_sum;
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                sqn_reg  <= sqn_reg << 2;
                srem_reg <= sge ? sr2 - strial : sr2;
                root_reg <= {root_reg[ttf_pkg::ROOT_W-2:0], sge};
            end
            ST_DINIT:
            begin
                drem_reg <= ttf_pkg::DREM_W'(num[ttf_pkg::NUM_W-1:ttf_pkg::QB]);
                dsh_reg  <= num[ttf_pkg::QB-1:0];
                q_reg    <= '0;
            end
            ST_DIV:
            begin
                drem_reg <= dge ? dr2 - {1'b0, root_reg} : dr2;
                dsh_reg  <= dsh_reg << 1;
                q_reg    <= q_new;
                if (cnt_last_div)
                begin
                    case (phase_reg)
                        PH_TAN:  tq_reg[comp_reg] <= qval;
                        PH_BIT:  bq_reg[comp_reg] <= qval;
                        default: nq_reg[comp_reg] <= qval;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    if (deg_reg)
                    begin
                        res_reg <= '{deg: 1'b1, default: '0};
                    end
                    else
                    begin
                        res_reg <= '{tx: tq_reg[0], ty: tq_reg[1], tz: tq_reg[2],
                                     bx: bq_reg[0], by: bq_reg[1], bz: bq_reg[2],
                                     nx: nq_reg[0], ny: nq_reg[1], nz: nq_reg[2],
                                     deg: 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/triangle_tangent_frame.sv -----
// Per-triangle tangent frame for a triangle-list vertex stream. Each beat on the
// input is one vertex (position Q16.16, texture coordinate Q8.16); every third
// vertex yields one result beat holding the unit tangent, bitangent and normal
// in signed Q1.14, or all zeros with degenerate set when the uv determinant or a
// vector length is zero. The first two vertices of a triangle are taken one per
// cycle; the third is taken as soon as the two-entry triangle queue has room.
// The back end works on one triangle at a time through one shared multiplier,
// a one-bit-per-cycle normalizing shifter, a 32-step square root per vector and
// a 16-step divider per component; a zero determinant or a vector that turns
// out zero ends the work on a triangle early. A finished result waits in the
// output register while the back end starts on the next triangle.
module triangle_tangent_frame
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [ttf_pkg::POS_W-1:0]  pos_x,
    input  logic signed [ttf_pkg::POS_W-1:0]  pos_y,
    input  logic signed [ttf_pkg::POS_W-1:0]  pos_z,
    input  logic signed [ttf_pkg::TEX_W-1:0]  tex_u,
    input  logic signed [ttf_pkg::TEX_W-1:0]  tex_v,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [ttf_pkg::UNIT_W-1:0] tangent_x,
    output logic signed [ttf_pkg::UNIT_W-1:0] tangent_y,
    output logic signed [ttf_pkg::UNIT_W-1:0] tangent_z,
    output logic signed [ttf_pkg::UNIT_W-1:0] bitangent_x,
    output logic signed [ttf_pkg::UNIT_W-1:0] bitangent_y,
    output logic signed [ttf_pkg::UNIT_W-1:0] bitangent_z,
    output logic signed [ttf_pkg::UNIT_W-1:0] normal_x,
    output logic signed [ttf_pkg::UNIT_W-1:0] normal_y,
    output logic signed [ttf_pkg::UNIT_W-1:0] normal_z,
    output logic                              degenerate
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    ttf_pkg::tri_t q_din;
    ttf_pkg::tri_t q_dout;
    logic          out_valid;
    ttf_pkg::res_t res;

    ttf_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .tex_u  (tex_u),
        .tex_v  (tex_v),
        .q_push (q_push),
        .q_data (q_din),
        .q_full (q_full)
    );

    ttf_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    ttf_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_dout),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .pop       (pop),
        .res       (res)
    );

    assign empty       = ~out_valid;
    assign tangent_x   = res.tx;
    assign tangent_y   = res.ty;
    assign tangent_z   = res.tz;
    assign bitangent_x = res.bx;
    assign bitangent_y = res.by;
    assign bitangent_z = res.bz;
    assign normal_x    = res.nx;
    assign normal_y    = res.ny;
    assign normal_z    = res.nz;
    assign degenerate  = res.deg;

endmodule

// ----- sv/ttf_checker.sv -----
module ttf_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              empty,
    input logic                              pop,
    input logic signed [ttf_pkg::UNIT_W-1:0] tangent_x,
    input logic signed [ttf_pkg::UNIT_W-1:0] tangent_y,
    input logic signed [ttf_pkg::UNIT_W-1:0] tangent_z,
    input logic signed [ttf_pkg::UNIT_W-1:0] bitangent_x,
    input logic signed [ttf_pkg::UNIT_W-1:0] bitangent_y,
    input logic signed [ttf_pkg::UNIT_W-1:0] bitangent_z,
    input logic signed [ttf_pkg::UNIT_W-1:0] normal_x,
    input logic signed [ttf_pkg::UNIT_W-1:0] normal_y,
    input logic signed [ttf_pkg::UNIT_W-1:0] normal_z,
    input logic                              degenerate
);

    // degenerate beat carries zero vectors
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && degenerate) |->
            (tangent_x == 0 && tangent_y == 0 && tangent_z == 0 &&
             bitangent_x == 0 && bitangent_y == 0 && bitangent_z == 0 &&
             normal_x == 0 && normal_y == 0 && normal_z == 0))
        else $error("degenerate beat with nonzero vector");

    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !degenerate) |-> (normal_x != 0 || normal_y != 0 || normal_z != 0))
        else $error("zero normal without degenerate");

    a_tan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !degenerate) |->
            (tangent_x >= -16'sd16384 && tangent_x <= 16'sd16384 &&
             bitangent_x >= -16'sd16384 && bitangent_x <= 16'sd16384))
        else $error("unit component out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(normal_x) && $stable(degenerate)))
        else $error("result beat changed before pop");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (.*);

// ----- tb/tb_triangle_tangent_frame.sv -----
`timescale 1ns / 1ps

module tb_triangle_tangent_frame;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        ttf_pkg::corner_t v[3];
        bit               typed;
        ttf_pkg::res_t    want;
    } tri_row_t;

    localparam logic signed [31:0] ONE_P = 32'sh0001_0000;
    localparam logic signed [23:0] ONE_T = 24'sh01_0000;
    localparam logic signed [31:0] MAX_P = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN_P = 32'sh8000_0000;
    localparam logic signed [23:0] MAX_T = 24'sh7f_ffff;
    localparam logic signed [23:0] MIN_T = 24'sh80_0000;
    localparam int RAND_TRIS = 217;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic signed [ttf_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [ttf_pkg::TEX_W-1:0] tex_u, tex_v;
    logic empty;
    logic pop;
    logic signed [ttf_pkg::UNIT_W-1:0] tangent_x, tangent_y, tangent_z;
    logic signed [ttf_pkg::UNIT_W-1:0] bitangent_x, bitangent_y, bitangent_z;
    logic signed [ttf_pkg::UNIT_W-1:0] normal_x, normal_y, normal_z;
    logic degenerate;

    ttf_pkg::res_t frames_due[$];
    tri_row_t      rows[$];
    int            errors;
    int            beats_sent;
    bit            calm;

    // held corners of the current triangle
    int               held;
    ttf_pkg::corner_t corner_q[2];

    triangle_tangent_frame uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_triangle_tangent_frame NOT OK");
        $finish;
    end

    function automatic int bit_len(logic [127:0] x);
        for (int i = 127; i >= 0; i--)
            if (x[i])
                return i + 1;
        return 0;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit make_unit(input wide_t w[3], output int q[3]);
        logic [127:0] mg[3];
        logic [127:0] orv;
        logic [63:0]  m[3];
        logic [63:0]  s2;
        logic [63:0]  len;
        logic [63:0]  r;
        bit           ng[3];
        int           l;
        orv = 0;
        s2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            ng[i] = w[i][127];
            mg[i] = ng[i] ? -w[i] : w[i];
            orv |= mg[i];
            q[i] = 0;
        end
        if (orv == 0)
            return 1'b0;
        l = bit_len(orv);
        for (int i = 0; i < 3; i++)
        begin
            if (l > 31)
                m[i] = 64'((mg[i] >> (l - 31)) & 128'h7fff_ffff);
            else
                m[i] = 64'((mg[i] << (31 - l)) & 128'h7fff_ffff);
            s2 += m[i] * m[i];
        end
        len = floor_sqrt(s2);
        for (int i = 0; i < 3; i++)
        begin
            r = ((m[i] << ttf_pkg::FRAC_W) + (len >> 1)) / len;
            q[i] = ng[i] ? -int'(r) : int'(r);
        end
        return 1'b1;
    endfunction

    function automatic ttf_pkg::res_t frame_of(ttf_pkg::corner_t a, ttf_pkg::corner_t b,
                                               ttf_pkg::corner_t c);
        longint        e1[3], e2[3];
        longint        du1, dv1, du2, dv2, det;
        wide_t         tw[3], bw[3], nw[3];
        int            t[3], bt[3], n[3];
        bit            ok;
        ttf_pkg::res_t f;
        e1[0] = longint'(b.x) - a.x;  e2[0] = longint'(c.x) - a.x;
        e1[1] = longint'(b.y) - a.y;  e2[1] = longint'(c.y) - a.y;
        e1[2] = longint'(b.z) - a.z;  e2[2] = longint'(c.z) - a.z;
        du1 = longint'(b.u) - a.u;
        dv1 = longint'(b.v) - a.v;
        du2 = longint'(c.u) - a.u;
        dv2 = longint'(c.v) - a.v;
        det = du1 * dv2 - du2 * dv1;
        for (int i = 0; i < 3; i++)
        begin
            tw[i] = wide_t'(dv2) * wide_t'(e1[i]) - wide_t'(dv1) * wide_t'(e2[i]);
            bw[i] = wide_t'(du1) * wide_t'(e2[i]) - wide_t'(du2) * wide_t'(e1[i]);
        end
        ok = det != 0;
        if (ok)
            ok = make_unit(tw, t);
        if (ok)
            ok = make_unit(bw, bt);
        if (ok && det < 0)
            for (int i = 0; i < 3; i++)
            begin
                t[i] = -t[i];
                bt[i] = -bt[i];
            end
        if (ok)
        begin
            nw[0] = wide_t'(longint'(t[1]) * bt[2] - longint'(t[2]) * bt[1]);
            nw[1] = wide_t'(longint'(t[2]) * bt[0] - longint'(t[0]) * bt[2]);
            nw[2] = wide_t'(longint'(t[0]) * bt[1] - longint'(t[1]) * bt[0]);
            ok = make_unit(nw, n);
        end
        f = '0;
        if (ok)
        begin
            f.tx = 16'(t[0]);  f.ty = 16'(t[1]);  f.tz = 16'(t[2]);
            f.bx = 16'(bt[0]); f.by = 16'(bt[1]); f.bz = 16'(bt[2]);
            f.nx = 16'(n[0]);  f.ny = 16'(n[1]);  f.nz = 16'(n[2]);
        end
        f.deg = !ok;
        return f;
    endfunction

    function automatic ttf_pkg::corner_t vtx(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z, logic signed [23:0] u,
                                             logic signed [23:0] v);
        ttf_pkg::corner_t c;
        c.x = x; c.y = y; c.z = z; c.u = u; c.v = v;
        return c;
    endfunction

    function automatic ttf_pkg::res_t flat_frame();
        ttf_pkg::res_t f;
        f = '0;
        f.deg = 1'b1;
        return f;
    endfunction

    function automatic ttf_pkg::corner_t rand_vtx();
        ttf_pkg::corner_t c;
        int sp, st;
        sp = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 28);
        st = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 20);
        c.x = $signed(32'($urandom)) >>> sp;
        c.y = $signed(32'($urandom)) >>> sp;
        c.z = $signed(32'($urandom)) >>> sp;
        c.u = $signed(24'($urandom)) >>> st;
        c.v = $signed(24'($urandom)) >>> st;
        return c;
    endfunction

    task automatic add_row(ttf_pkg::corner_t a, ttf_pkg::corner_t b, ttf_pkg::corner_t c,
                           bit typed, ttf_pkg::res_t want);
        tri_row_t r;
        r.v[0] = a; r.v[1] = b; r.v[2] = c;
        r.typed = typed;
        r.want = want;
        rows = {rows, r};
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_vertex(ttf_pkg::corner_t c, bit typed, ttf_pkg::res_t want);
        bit            taken;
        ttf_pkg::res_t f;
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        pos_x <= c.x; pos_y <= c.y; pos_z <= c.z;
        tex_u <= c.u; tex_v <= c.v;
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        while (!taken);
        beats_sent++;
        calm = beats_sent >= 300 && beats_sent < 420;
        if (held < 2)
        begin
            corner_q[held] = c;
            held++;
        end
        else
        begin
            held = 0;
            f = typed ? want : frame_of(corner_q[0], corner_q[1], c);
            frames_due = {frames_due, f};
        end
    endtask

    // result side: pop at random, check on each accepted beat
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            pop <= calm || $urandom_range(0, 99) >= 38;
        end
    end

    initial
    begin
        ttf_pkg::res_t e;
        forever
        begin
            @(negedge clk);
            if (rst_n && pop && !empty)
            begin
                if (frames_due.size() == 0)
                begin
                    report("unexpected beat", 1, 0);
                end
                else
                begin
                    e = frames_due.pop_front();
                    if (tangent_x != e.tx)   report("tangent_x", tangent_x, e.tx);
                    if (tangent_y != e.ty)   report("tangent_y", tangent_y, e.ty);
                    if (tangent_z != e.tz)   report("tangent_z", tangent_z, e.tz);
                    if (bitangent_x != e.bx) report("bitangent_x", bitangent_x, e.bx);
                    if (bitangent_y != e.by) report("bitangent_y", bitangent_y, e.by);
                    if (bitangent_z != e.bz) report("bitangent_z", bitangent_z, e.bz);
                    if (normal_x != e.nx)    report("normal_x", normal_x, e.nx);
                    if (normal_y != e.ny)    report("normal_y", normal_y, e.ny);
                    if (normal_z != e.nz)    report("normal_z", normal_z, e.nz);
                    if (degenerate != e.deg) report("degenerate", degenerate, e.deg);
                end
            end
        end
    end

    initial
    begin
        ttf_pkg::res_t    unit_f;
        ttf_pkg::corner_t a, b, c;
        rst_n = 1'b0;
        push  = 1'b0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        tex_u = '0; tex_v = '0;
        errors = 0;
        beats_sent = 0;
        calm = 1'b0;
        held = 0;

        unit_f = '0;
        unit_f.tx = 16'sd16384;
        unit_f.by = 16'sd16384;
        unit_f.nz = 16'sd16384;
        add_row(vtx(0, 0, 0, 0, 0), vtx(ONE_P, 0, 0, ONE_T, 0),
                vtx(0, ONE_P, 0, 0, ONE_T), 1'b1, unit_f);
        // zero uv determinant
        add_row(vtx(0, 0, 0, ONE_T, ONE_T), vtx(ONE_P, 0, 0, ONE_T, ONE_T),
                vtx(0, ONE_P, 0, ONE_T, ONE_T), 1'b1, flat_frame());
        // zero-length tangent and bitangent
        add_row(vtx(ONE_P, ONE_P, ONE_P, 0, 0), vtx(ONE_P, ONE_P, ONE_P, ONE_T, 0),
                vtx(ONE_P, ONE_P, ONE_P, 0, ONE_T), 1'b1, flat_frame());
        // parallel tangent and bitangent
        add_row(vtx(0, 0, 0, 0, 0), vtx(ONE_P, 0, 0, ONE_T, 0),
                vtx(2 * ONE_P, 0, 0, 0, ONE_T), 1'b1, flat_frame());
        // negative determinant
        add_row(vtx(0, 0, 0, 0, 0), vtx(ONE_P, 0, ONE_P, 0, ONE_T),
                vtx(0, ONE_P, 0, ONE_T, 0), 1'b0, '0);
        add_row(vtx(MAX_P, MIN_P, MAX_P, MAX_T, MIN_T), vtx(MIN_P, MAX_P, MIN_P, MIN_T, MAX_T),
                vtx(MAX_P, MAX_P, MIN_P, MAX_T, MAX_T), 1'b0, '0);
        add_row(vtx(MIN_P, MIN_P, MIN_P, MIN_T, MIN_T), vtx(MAX_P, MAX_P, MAX_P, MAX_T, 0),
                vtx(0, MIN_P, MAX_P, MAX_T, MIN_T), 1'b0, '0);
        add_row(vtx(0, 0, 0, 0, 0), vtx(1, 0, 0, 1, 0), vtx(0, 1, 1, 0, 1), 1'b0, '0);

        for (int i = 0; i < RAND_TRIS; i++)
        begin
            a = rand_vtx();
            b = rand_vtx();
            c = rand_vtx();
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    b.u = a.u; b.v = a.v; c.u = a.u; c.v = a.v;
                end
                2:
                begin
                    b.x = a.x; b.y = a.y; b.z = a.z;
                    c.x = a.x; c.y = a.y; c.z = a.z;
                end
                3:
                begin
                    c.x = a.x + 2 * (b.x - a.x);
                    c.y = a.y + 2 * (b.y - a.y);
                    c.z = a.z + 2 * (b.z - a.z);
                end
                default: ;
            endcase
            add_row(a, b, c, 1'b0, '0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
            for (int k = 0; k < 3; k++)
                send_vertex(rows[r].v[k], rows[r].typed, rows[r].want);
        push <= 1'b0;

        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        if (errors == 0)
            $display("tb_triangle_tangent_frame OK");
        else
            $display("tb_triangle_tangent_frame NOT OK");
        $finish;
    end

endmodule
